>>> hdl/assert_macros.svh
// Assertion macros shared by the prime factoriser RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pf_pkg.sv
// Shared constants and controller/datapath interface types for the prime factoriser
package pf_pkg;

    // Default width of the integer being factored
    localparam int VALUE_BITS_DEF = 31;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a new value, restart trial divisor at 2
        logic div_start;  // arm the divider with the current cofactor
        logic div_step;   // one restoring-division step
        logic next_d;     // advance to the next trial divisor
        logic emit_d;     // send divisor as a factor, keep the quotient
        logic emit_n;     // send the remaining cofactor as the final factor
    } pf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic trial_end;  // cofactor below 2 or divisor squared exceeds it
        logic div_done;   // all quotient bits produced
        logic rem_zero;   // divisor divides the cofactor evenly
        logic quot_one;   // quotient is 1, so this factor is the last
        logic out_free;   // output register can take a new factor
    } pf_sts_t;

endpackage

>>> hdl/pf_ctrl.sv
// Controller state machine sequencing trial division and factor output
module pf_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pf_pkg::pf_sts_t sts,
    output pf_pkg::pf_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV,
        ST_EMIT_D,
        ST_EMIT_N
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (sts.trial_end)
                begin
                    state_next = ST_EMIT_N;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!sts.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else if (sts.rem_zero)
                begin
                    state_next = ST_EMIT_D;
                end
                else
                begin
                    cmd.next_d = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_EMIT_D:
            begin
                // wait for a free output slot; retry the same divisor afterwards
                if (sts.out_free)
                begin
                    cmd.emit_d = 1'b1;
                    state_next = sts.quot_one ? ST_IDLE : ST_TEST;
                end
            end
            ST_EMIT_N:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_n = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/pf_dpath.sv
// Datapath: cofactor, trial divisor and its square, bit-serial divider, output register
module pf_dpath
#(
    parameter int VALUE_BITS = pf_pkg::VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  pf_pkg::pf_cmd_t       cmd,
    output pf_pkg::pf_sts_t       sts,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [VALUE_BITS-1:0] out_factor,
    output logic                  out_last
);

    // Trial divisor never exceeds sqrt(cofactor) + 2
    localparam int D_W   = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_W  = 2 * D_W;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] n_reg;
    logic [D_W-1:0]        d_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [D_W-1:0]        rem_reg;
    logic [VALUE_BITS-1:0] quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  valid_reg;
    logic [VALUE_BITS-1:0] factor_reg;
    logic                  last_reg;

    logic [D_W:0]          rem_shift;
    logic                  sub_ok;
    logic [D_W:0]          rem_diff;
    logic [D_W-1:0]        rem_next;

    // One restoring-division step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[VALUE_BITS-1]};
        sub_ok    = (rem_shift >= {1'b0, d_reg});
        rem_diff  = rem_shift - {1'b0, d_reg};
        rem_next  = sub_ok ? rem_diff[D_W-1:0] : rem_shift[D_W-1:0];
    end

    // Cofactor, trial divisor and square
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg  <= value;
            d_reg  <= D_W'(2);
            sq_reg <= SQ_W'(4);
        end
        else
        begin
            if (cmd.next_d)
            begin
                if (d_reg == D_W'(2))
                begin
                    d_reg  <= D_W'(3);
                    sq_reg <= SQ_W'(9);
                end
                else
                begin
                    // (d+2)^2 = d^2 + 4d + 4
                    d_reg  <= d_reg + D_W'(2);
                    sq_reg <= sq_reg + SQ_W'({d_reg, 2'b00}) + SQ_W'(4);
                end
            end
            if (cmd.emit_d)
            begin
                n_reg <= quo_reg;
            end
        end
    end

    // Divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= n_reg;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[VALUE_BITS-2:0], sub_ok};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // Output register: holds a factor until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit_d || cmd.emit_n)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_d)
        begin
            factor_reg <= VALUE_BITS'(d_reg);
            last_reg   <= (quo_reg == VALUE_BITS'(1));
        end
        else if (cmd.emit_n)
        begin
            factor_reg <= n_reg;
            last_reg   <= 1'b1;
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.trial_end = (n_reg[VALUE_BITS-1:1] == '0) || (sq_reg > SQ_W'(n_reg));
        sts.div_done  = (cnt_reg == CNT_W'(VALUE_BITS));
        sts.rem_zero  = (rem_reg == '0);
        sts.quot_one  = (quo_reg == VALUE_BITS'(1));
        sts.out_free  = !valid_reg || out_ready;
    end

    assign out_valid  = valid_reg;
    assign out_factor = factor_reg;
    assign out_last   = last_reg;

endmodule

>>> hdl/prime_factorizer.sv
// Top level of the trial-division prime factoriser
//
// Usage:
//   Slave channel (s_*): one transaction carries an integer to factor in
//   s_tdata. Master channel (m_*): a run of transactions, one prime factor
//   each in ascending order with repeats; m_tlast marks the final one.
//   Inputs 0 and 1 give a single transaction holding themselves.
// Operation:
//   One value is worked on at a time; s_tready is high only when idle.
//   Each trial (2, then odd numbers) runs the restoring divider, which gives
//   one quotient bit per cycle; a factor found is then sent. Trials run up
//   to the square root of the cofactor; 0, 1, 2 and 3 need no trial at all.
// Reset:
//   rst_n clears the controller and the output valid; the block comes out
//   ready for a value with nothing pending.
// Stalls:
//   A factor waits in the output register while m_tready is low; the
//   search goes on and halts only when another factor is due. The next
//   value is accepted while the last run's final factor still waits.
`include "assert_macros.svh"

module prime_factorizer
#(
    parameter  int VALUE_BITS = pf_pkg::VALUE_BITS_DEF,
    localparam int TDATA_W    = ((VALUE_BITS + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [VALUE_BITS-1:0] value, rest zero
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [VALUE_BITS-1:0] factor, rest zero
    output logic               m_tlast
);

    pf_pkg::pf_cmd_t       cmd;
    pf_pkg::pf_sts_t       sts;
    logic [VALUE_BITS-1:0] factor;

    pf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pf_dpath
    #(
        .VALUE_BITS (VALUE_BITS)
    )
    u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (s_tdata[VALUE_BITS-1:0]),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_factor (factor),
        .out_last   (m_tlast)
    );

    // Pad the factor up to whole bytes
    assign m_tdata = TDATA_W'(factor);

    // The block is busy right after taking a value
    `PF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "prime_factorizer: ready again right after accepting a value")

    // A run still in progress keeps the input side closed
    `PF_ASSERT_IMP(a_busy_mid_run, clk, rst_n, m_tvalid && !m_tlast, !s_tready,
        "prime_factorizer: idle while a run is incomplete")

    // Only a final transaction may carry 0 or 1
    `PF_ASSERT_IMP(a_prime_mid_run, clk, rst_n, m_tvalid && !m_tlast,
        factor[VALUE_BITS-1:1] != '0,
        "prime_factorizer: factor below 2 inside a run")

endmodule

>>> verif/pf_checker.sv
// Checker for the prime factoriser: predicts factor runs and compares the master stream
`timescale 1ns / 100ps

module pf_checker
#(
    parameter  int VALUE_BITS = pf_pkg::VALUE_BITS_DEF,
    localparam int TDATA_W    = ((VALUE_BITS + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,      // [VALUE_BITS-1:0] value, rest zero
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,      // [VALUE_BITS-1:0] factor, rest zero
    input  logic               m_tlast,
    output int unsigned        fail_count,
    output int unsigned        outstanding
);

    typedef struct packed {
        logic [VALUE_BITS-1:0] factor;
        logic                  last;
    } factor_result_t;

    // Factors still owed by the block, oldest first
    factor_result_t expected_factors[$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    // Trial division from 2; whatever is left above 1 is prime
    function automatic void predict_factors(input logic [VALUE_BITS-1:0] value);
        longint unsigned rest;
        longint unsigned divisor;
        longint unsigned found[$];
        factor_result_t  item;
        rest = value;
        if (rest <= 1)
        begin
            found.push_back(rest);
        end
        else
        begin
            for (divisor = 2; divisor * divisor <= rest; divisor++)
            begin
                while (rest % divisor == 0)
                begin
                    found.push_back(divisor);
                    rest = rest / divisor;
                end
            end
            if (rest > 1)
            begin
                found.push_back(rest);
            end
        end
        foreach (found[i])
        begin
            item.factor = found[i][VALUE_BITS-1:0];
            item.last   = (i == found.size() - 1);
            expected_factors.push_back(item);
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t pf_checker: %s", $time, what);
        fail_count++;
    endtask

    // Watch both channels; values read here are those before the edge
    always @(posedge clk)
    begin
        factor_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_factors(s_tdata[VALUE_BITS-1:0]);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_factors.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected factor %0d last %0b",
                                              m_tdata[VALUE_BITS-1:0], m_tlast));
                end
                else
                begin
                    want = expected_factors.pop_front();
                    if (m_tdata[VALUE_BITS-1:0] != want.factor)
                    begin
                        report_mismatch($sformatf("factor %0d, expected %0d",
                                                  m_tdata[VALUE_BITS-1:0], want.factor));
                    end
                    if (m_tlast != want.last)
                    begin
                        report_mismatch($sformatf("tlast %0b on factor %0d, expected %0b",
                                                  m_tlast, want.factor, want.last));
                    end
                    if (m_tdata[TDATA_W-1:VALUE_BITS] != '0)
                    begin
                        report_mismatch($sformatf("tdata padding not zero: %h", m_tdata));
                    end
                end
            end
            outstanding <= expected_factors.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// Testbench top for the prime factoriser: stimulus, stream idling and verdict
`timescale 1ns / 100ps

module tb_top;

    localparam int VB               = pf_pkg::VALUE_BITS_DEF;
    localparam int TDATA_W          = ((VB + 7) / 8) * 8;
    localparam int CYCLE_LIMIT      = 6000000;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES      = 50;
    localparam int RANDOM_ITEMS     = 100;
    localparam int MAX_GAP          = 12;

    // Edge cases: zero, one, small primes, squares, max result count, largest prime
    localparam logic [VB-1:0] CORNER_VALUES [20] = '{
        31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd8, 31'd9, 31'd12,
        31'd25, 31'd49, 31'd97, 31'd65521, 31'd30030, 31'd3996001,
        31'd1073741824, 31'd1162261467, 31'd2147483646, 31'd2147483647
    };

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               m_tready = 1'b0;
    logic               s_tready;
    logic               m_tvalid;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned cycles        = 0;
    int unsigned send_gap      = 0;
    bit          no_idle       = 1'b0;
    bit          long_hold_req = 1'b0;

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[prime_factorizer] ERROR");
            $finish;
        end
    end

    prime_factorizer #(.VALUE_BITS(VB)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    pf_checker #(.VALUE_BITS(VB)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Mostly smooth numbers, so trial division stays short; cofactor below 2^14
    function automatic logic [VB-1:0] random_value();
        longint unsigned acc;
        int unsigned     top_bit;
        int unsigned     factor;
        case ($urandom_range(0, 9))
            0: return VB'($urandom_range(0, 1023));
            1: return VB'($urandom_range(2, 16383));
            default:
            begin
                acc     = $urandom_range(1, 16383);
                top_bit = $urandom_range(8, VB);
                for (int k = 0; k < 40; k++)
                begin
                    factor = $urandom_range(2, 127);
                    if (acc * factor >= (64'd1 << top_bit))
                        break;
                    acc = acc * factor;
                end
                return VB'(acc);
            end
        endcase
    endfunction

    // One slave transaction; valid stays high when the next gap is zero
    task automatic send_value(input logic [VB-1:0] value);
        repeat (send_gap) @(posedge clk);
        s_tdata  <= TDATA_W'(value);
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        send_gap = draw_gap();
        if (send_gap != 0)
            s_tvalid <= 1'b0;
    endtask

    // Stop offering and wait until every owed factor has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        send_gap = 0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Master side: random stalls per factor, one long hold on request
    initial
    begin
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            do @(posedge clk); while (!m_tvalid);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD_CYCLES;
            end
            else
            begin
                stall = draw_gap();
            end
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (CORNER_VALUES[i])
            send_value(CORNER_VALUES[i]);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 10 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            // block fills up while the master side holds off
            if (i == 40)
                long_hold_req = 1'b1;
            if (i == 70)
                wait_drained();
            send_value(random_value());
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("[prime_factorizer] OK");
        else
            $display("[prime_factorizer] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/pf_pkg.sv
hdl/pf_ctrl.sv
hdl/pf_dpath.sv
hdl/prime_factorizer.sv
verif/pf_checker.sv
verif/tb_top.sv
